/* src/satl_pkg.sv */
package satl_pkg;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_BITS = 2'd0,
        CFG_INDEX_BITS  = 2'd1,
        CFG_WAYS_LOG2   = 2'd2
    } t_cfg_idx;

    // Register reset values and clamps
    localparam logic [3:0] OFFSET_RST = 4'd6;
    localparam logic [2:0] INDEX_RST  = 3'd6;
    localparam logic [1:0] WAYS_RST   = 2'd3;
    localparam logic [3:0] OFFSET_MAX = 4'd12;
    localparam int unsigned INDEX_MAX = 6;
    localparam int unsigned WAYS_MAX  = 3;

    // Replacement LFSR (Galois, right shift)
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // Result beat layout, lowest bit first
    localparam int unsigned CNT_W     = 32;
    localparam int unsigned VWAY_W    = 3;
    localparam int unsigned OUT_HIT   = 0;
    localparam int unsigned OUT_VWAY  = 1;
    localparam int unsigned OUT_HCNT  = OUT_VWAY + VWAY_W;
    localparam int unsigned OUT_MCNT  = OUT_HCNT + CNT_W;
    localparam int unsigned OUT_USED  = OUT_MCNT + CNT_W;
    localparam int unsigned OUT_W     = ((OUT_USED + 7) / 8) * 8;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

endpackage

/* src/set_assoc_cache_tag_lookup.sv */
// An accepted address beat is registered into stage 1, then into the result register that drives the master side.
// Throughput: one address per cycle while no result beat stalls, limited by the single read port
//   of the per-way tag RAMs; a miss updates its way in the compare stage and is bypassed to the
//   next lookup. Reset: synchronous, active low. After reset a clearing pass writes every
//   set row with o_s_tready low; configuration writes are taken throughout.
module set_assoc_cache_tag_lookup #(
    parameter int unsigned WAYS       = 8,
    parameter int unsigned MAX_SETS   = 64,
    parameter int unsigned ADDR_WIDTH = 40
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [satl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [satl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // address stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [((ADDR_WIDTH+7)/8)*8-1:0] i_s_tdata,  // address, zero pad
    // result stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [satl_pkg::OUT_W-1:0]     o_m_tdata   // hit, victim_way[3], hit_count[32],
                                                       // miss_count[32], zero pad
);
    import satl_pkg::*;

    // floor(log2()) of the size parameters
    localparam int unsigned IMAX   = $clog2(MAX_SETS + 1) - 1;
    localparam int unsigned WMAX   = $clog2(WAYS + 1) - 1;
    localparam int unsigned IB_CAP = (IMAX < INDEX_MAX) ? IMAX : INDEX_MAX;
    localparam int unsigned WB_CAP = (WMAX < WAYS_MAX) ? WMAX : WAYS_MAX;
    localparam int unsigned SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned ENT_W  = ADDR_WIDTH + 1;   // {valid, tag}

    // ---------------- configuration registers ----------------
    logic [3:0] r_offset_bits;
    logic [2:0] r_index_bits;
    logic [1:0] r_ways_log2;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= OFFSET_RST;
            r_index_bits  <= INDEX_RST;
            r_ways_log2   <= WAYS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data;
                CFG_INDEX_BITS:  r_index_bits  <= i_cfg_data[2:0];
                CFG_WAYS_LOG2:   r_ways_log2   <= i_cfg_data[1:0];
                default: ;       // unmapped index, dropped
            endcase
        end
    end

    // ---------------- clearing pass after reset ----------------
    logic             r_clr_busy;
    logic [SET_W-1:0] r_clr_ptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_ptr  <= '0;
        end else if (r_clr_busy) begin
            r_clr_ptr <= r_clr_ptr + 1'b1;
            if (r_clr_ptr == SET_W'(MAX_SETS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ---------------- stage 0: address split ----------------
    logic [ADDR_WIDTH-1:0] s0_addr;
    logic [ADDR_WIDTH-1:0] s0_block;
    logic [ADDR_WIDTH-1:0] s0_tag;
    logic [SET_W-1:0]      s0_set;
    logic [3:0]            s0_ob;
    logic [2:0]            s0_ib;
    logic [1:0]            s0_wb;
    logic [WAY_W-1:0]      s0_mask;
    logic                  s0_accept;
    logic                  s1_adv;

    assign s0_addr = i_s_tdata[ADDR_WIDTH-1:0];

    always_comb begin
        s0_ob = (r_offset_bits > OFFSET_MAX) ? OFFSET_MAX : r_offset_bits;
        s0_ib = (r_index_bits > 3'(IB_CAP)) ? 3'(IB_CAP) : r_index_bits;
        s0_wb = (r_ways_log2 > 2'(WB_CAP)) ? 2'(WB_CAP) : r_ways_log2;
        s0_block = s0_addr >> s0_ob;
        s0_tag   = s0_block >> s0_ib;
        for (int i = 0; i < SET_W; i++) begin
            s0_set[i] = s0_block[i] & (i < int'(s0_ib));
        end
        // ways in use - 1
        for (int i = 0; i < WAY_W; i++) begin
            s0_mask[i] = (i < int'(s0_wb));
        end
    end

    assign s0_accept  = i_s_tvalid && o_s_tready;

    // ---------------- stage 1 registers ----------------
    logic                  r_s1_valid;
    logic [SET_W-1:0]      r_s1_set;
    logic [ADDR_WIDTH-1:0] r_s1_tag;
    logic [WAY_W-1:0]      r_s1_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s0_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_accept) begin
            r_s1_set  <= s0_set;
            r_s1_tag  <= s0_tag;
            r_s1_mask <= s0_mask;
        end
    end

    // ---------------- per-way tag RAMs ----------------
    logic [ENT_W-1:0] r_rd [WAYS];
    logic [WAYS-1:0]  mem_we;
    logic [SET_W-1:0] mem_wa;
    logic [ENT_W-1:0] mem_wd;
    logic             s1_hit;
    logic [WAY_W-1:0] s1_way;

    assign mem_wa = r_clr_busy ? r_clr_ptr : r_s1_set;
    assign mem_wd = r_clr_busy ? '0 : {1'b1, r_s1_tag};

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            mem_we[w] = r_clr_busy || (s1_adv && !s1_hit && (s1_way == WAY_W'(w)));
        end
    end

    for (genvar g = 0; g < WAYS; g++) begin : g_way
        logic [ENT_W-1:0] mem [MAX_SETS];

        always_ff @(posedge i_clk) begin
            if (mem_we[g]) begin
                mem[mem_wa] <= mem_wd;
            end
            if (s0_accept) begin
                r_rd[g] <= mem[s0_set];
            end
        end
    end

    // Last fill, bypassed over the RAM read that happened at the same edge.
    logic                  r_lw_valid;
    logic [SET_W-1:0]      r_lw_set;
    logic [WAY_W-1:0]      r_lw_way;
    logic [ADDR_WIDTH-1:0] r_lw_tag;

    // ---------------- stage 1: compare and replace ----------------
    logic [15:0]      r_lfsr;
    logic [15:0]      n_lfsr;
    logic [CNT_W-1:0] r_hits;
    logic [CNT_W-1:0] r_misses;
    logic [CNT_W-1:0] n_hits;
    logic [CNT_W-1:0] n_misses;
    logic [WAYS-1:0]  s1_match;
    logic [WAY_W-1:0] s1_hit_way;
    logic [WAY_W-1:0] s1_victim;
    logic [ENT_W-1:0] s1_ent;

    logic             r_out_valid;

    assign s1_adv = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_clr_busy && (!r_s1_valid || s1_adv);

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            s1_ent = r_rd[w];
            if (r_lw_valid && (r_lw_set == r_s1_set) && (r_lw_way == WAY_W'(w))) begin
                s1_ent = {1'b1, r_lw_tag};
            end
            s1_match[w] = s1_ent[ADDR_WIDTH] && (s1_ent[ADDR_WIDTH-1:0] == r_s1_tag)
                          && ((WAY_W'(w) & ~r_s1_mask) == '0);
        end
        // lowest matching way wins
        s1_hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (s1_match[w]) begin
                s1_hit_way = WAY_W'(w);
            end
        end
        s1_hit    = |s1_match;
        s1_victim = r_lfsr[WAY_W-1:0] & r_s1_mask;
        s1_way    = s1_hit ? s1_hit_way : s1_victim;

        n_lfsr = {1'b0, r_lfsr[15:1]} ^ (r_lfsr[0] ? LFSR_TAPS : 16'h0000);
        n_hits   = (s1_hit && (r_hits != COUNT_MAX)) ? r_hits + 1'b1 : r_hits;
        n_misses = (!s1_hit && (r_misses != COUNT_MAX)) ? r_misses + 1'b1 : r_misses;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr     <= LFSR_SEED;
            r_hits     <= '0;
            r_misses   <= '0;
            r_lw_valid <= 1'b0;
        end else if (s1_adv) begin
            r_hits   <= n_hits;
            r_misses <= n_misses;
            if (!s1_hit) begin
                r_lfsr     <= n_lfsr;    // steps on a miss only
                r_lw_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && !s1_hit) begin
            r_lw_set <= r_s1_set;
            r_lw_way <= s1_victim;
            r_lw_tag <= r_s1_tag;
        end
    end

    // ---------------- result register ----------------
    logic                r_out_hit;
    logic [VWAY_W-1:0]   r_out_way;
    logic [CNT_W-1:0]    r_out_hcnt;
    logic [CNT_W-1:0]    r_out_mcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_hit  <= s1_hit;
            r_out_way  <= VWAY_W'(s1_way);
            r_out_hcnt <= n_hits;
            r_out_mcnt <= n_misses;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'({r_out_mcnt, r_out_hcnt, r_out_way, r_out_hit});

endmodule

/* src/satl_checker.sv */
module satl_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_s_tready,
    input logic                       o_m_tvalid,
    input logic                       i_m_tready,
    input logic [satl_pkg::OUT_W-1:0] o_m_tdata
);
    import satl_pkg::*;

    logic             out_hit;
    logic [CNT_W-1:0] out_hcnt;
    logic [CNT_W-1:0] out_mcnt;

    assign out_hit  = o_m_tdata[OUT_HIT];
    assign out_hcnt = o_m_tdata[OUT_HCNT +: CNT_W];
    assign out_mcnt = o_m_tdata[OUT_MCNT +: CNT_W];

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat changed while stalled");

    // clearing pass: no lookup and no result right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready && !o_m_tvalid)
        else $error("stream active right after reset");

    // the counter matching the outcome includes this access
    a_cnt_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (out_hit ? (out_hcnt != '0) : (out_mcnt != '0)))
        else $error("counter does not include this access");

    // counters never go backward from one beat to the next
    a_cnt_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_m_tvalid && i_m_tready) && $past(i_rst_n) && o_m_tvalid
        |-> (out_hcnt >= $past(out_hcnt)) && (out_mcnt >= $past(out_mcnt)))
        else $error("hit or miss counter decreased");

endmodule

bind set_assoc_cache_tag_lookup satl_checker u_satl_checker (.*);

/* verif/set_assoc_cache_tag_lookup_test.sv */
module set_assoc_cache_tag_lookup_test;
    import satl_pkg::*;

    // Block geometry, kept at the defaults of the block
    localparam int unsigned WAYS         = 8;
    localparam int unsigned MAX_SETS     = 64;
    localparam int unsigned ADDR_WIDTH   = 40;
    localparam int unsigned ADDR_BUS_W   = ((ADDR_WIDTH + 7) / 8) * 8;
    localparam int unsigned SETS_LOG2    = $clog2(MAX_SETS);  // floor, sets are a power of two
    localparam int unsigned LINE_COUNT   = WAYS * MAX_SETS;
    localparam int unsigned LATENCY      = 2;
    localparam int unsigned RANDOM_ITEMS = 1850;
    localparam int unsigned POOL_SIZE    = 16;

    // Index code with no register behind it; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    // One result beat, hit in bit 0
    typedef struct packed {
        logic [CNT_W-1:0]  misses;
        logic [CNT_W-1:0]  hits;
        logic [VWAY_W-1:0] way;
        logic              hit;
    } t_lookup_result;

    // One row of the directed plan: a register write or an address beat
    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [39:0]           addr;
        bit                    known;   // expectation typed in, not predicted
        t_lookup_result        fixed;
    } t_plan_row;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [ADDR_BUS_W-1:0]  i_s_tdata   = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [OUT_W-1:0]       o_m_tdata;

    set_assoc_cache_tag_lookup #(
        .WAYS       (WAYS),
        .MAX_SETS   (MAX_SETS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Run limit: far above the slowest legal run (every beat hit by the longest gap on
    // both sides, plus the clearing pass after reset)
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // Predictor state: its own copy of the lines, the LFSR, the
    // counters and the three registers. Reset happens once, so the
    // declarations carry the reset values.
    // ---------------------------------------------------------------
    logic [39:0]      line_tag   [LINE_COUNT];
    bit               line_valid [LINE_COUNT] = '{default: 1'b0};
    logic [15:0]      repl_lfsr  = LFSR_SEED;
    logic [CNT_W-1:0] hits_seen  = '0;
    logic [CNT_W-1:0] misses_seen = '0;
    logic [3:0]       cfg_offset = OFFSET_RST;
    logic [2:0]       cfg_index  = INDEX_RST;
    logic [1:0]       cfg_ways   = WAYS_RST;

    t_lookup_result   expected_lookups [$];
    int unsigned      errors = 0;
    bit               calm = 1'b0;   // phase with no idling on either side
    int unsigned      ready_hold = 0;

    // Look up one address, update the lines and counters, return the beat it causes
    function automatic t_lookup_result lookup_predict(input logic [39:0] addr);
        int unsigned    ob, ib, wb, nways, set_no, base, way;
        logic [39:0]    blk, tag;
        bit             found;
        bit             lsb;
        t_lookup_result r;
        ob = (cfg_offset > OFFSET_MAX) ? OFFSET_MAX : cfg_offset;
        ib = (cfg_index > INDEX_MAX) ? INDEX_MAX : cfg_index;
        if (ib > SETS_LOG2) ib = SETS_LOG2;
        wb = (cfg_ways > WAYS_MAX) ? WAYS_MAX : cfg_ways;
        nways = 1 << wb;
        blk = addr >> ob;
        set_no = int'(blk & ((40'd1 << ib) - 40'd1));
        tag = blk >> ib;
        base = set_no * WAYS;
        found = 1'b0;
        way = 0;
        // lowest valid matching way wins when a tag sits in several ways
        for (int w = 0; w < nways; w++) begin
            if (!found && line_valid[base + w] && line_tag[base + w] == tag) begin
                found = 1'b1;
                way = w;
            end
        end
        if (found) begin
            if (hits_seen != COUNT_MAX) hits_seen++;
        end else begin
            // victim from the LFSR before it steps; it steps on misses only
            way = int'(repl_lfsr) & (nways - 1);
            lsb = repl_lfsr[0];
            repl_lfsr = repl_lfsr >> 1;
            if (lsb) repl_lfsr = repl_lfsr ^ LFSR_TAPS;
            line_tag[base + way] = tag;
            line_valid[base + way] = 1'b1;
            if (misses_seen != COUNT_MAX) misses_seen++;
        end
        r.hit = found;
        r.way = way[VWAY_W-1:0];
        r.hits = hits_seen;
        r.misses = misses_seen;
        return r;
    endfunction

    // Mostly back to back, some short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [39:0] random_address();
        logic [39:0] a;
        a = 40'({$urandom, $urandom});
        if ($urandom_range(0, 3) == 0) a = a & 40'hF_FFFF;
        return a;
    endfunction

    // ---------------------------------------------------------------
    // Drivers. Everything changes by NBA right after a rising edge;
    // handshakes are judged on the values seen before the edge.
    // ---------------------------------------------------------------

    // Send one address beat after a random gap; predict it once accepted.
    // tvalid stays high on return so the next beat can follow back to back.
    task automatic push_address(input logic [39:0] addr, input bit known,
                                input t_lookup_result fixed);
        int unsigned    gap;
        t_lookup_result pred;
        i_cfg_valid <= 1'b0;
        gap = pick_gap();
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= addr;
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready));
        pred = lookup_predict(addr);
        expected_lookups = {expected_lookups, (known ? fixed : pred)};
    endtask

    // Register write, only once every expected beat is out (block idle)
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_s_tvalid <= 1'b0;
        while (expected_lookups.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        // register widths mask the write data
        case (idx)
            CFG_OFFSET_BITS: cfg_offset = data;
            CFG_INDEX_BITS:  cfg_index  = data[2:0];
            CFG_WAYS_LOG2:   cfg_ways   = data[1:0];
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------
    // Result side: random back-pressure and the in-order check
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin : result_check
        t_lookup_result got, want;
        if (ready_hold != 0) begin
            i_m_tready <= 1'b0;
            ready_hold--;
        end else begin
            i_m_tready <= 1'b1;
            ready_hold = pick_gap();
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[OUT_USED-1:0];
            if (expected_lookups.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual %0h",
                         $time, o_m_tdata);
            end else begin
                want = expected_lookups.pop_front();
                if (got.hit !== want.hit)
                    report_mismatch("hit", 32'(want.hit), 32'(got.hit));
                if (got.way !== want.way)
                    report_mismatch("victim_way", 32'(want.way), 32'(got.way));
                if (got.hits !== want.hits)
                    report_mismatch("hit_count", want.hits, got.hits);
                if (got.misses !== want.misses)
                    report_mismatch("miss_count", want.misses, got.misses);
            end
        end
    end

    // ---------------------------------------------------------------
    // Directed plan
    // ---------------------------------------------------------------
    t_plan_row plan [$];

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        t_plan_row r;
        r = '{is_write: 1'b1, reg_idx: idx, reg_data: data, addr: '0, known: 1'b0,
              fixed: '0};
        plan = {plan, r};
    endfunction

    function automatic void add_access(input logic [39:0] addr);
        t_plan_row r;
        r = '{is_write: 1'b0, reg_idx: '0, reg_data: '0, addr: addr, known: 1'b0,
              fixed: '0};
        plan = {plan, r};
    endfunction

    function automatic void add_known(input logic [39:0] addr, input logic hit,
                                      input logic [2:0] way, input logic [31:0] hits,
                                      input logic [31:0] misses);
        t_plan_row r;
        r = '{is_write: 1'b0, reg_idx: '0, reg_data: '0, addr: addr, known: 1'b1,
              fixed: '{misses: misses, hits: hits, way: way, hit: hit}};
        plan = {plan, r};
    endfunction

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin : stimulus
        t_plan_row   row;
        int unsigned total, n, k, b;
        logic [39:0] addr;
        logic [39:0] addr_pool [POOL_SIZE];

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset split: 64-byte lines, 64 sets, 8 ways. LFSR seed gives way 1, then way 0.
        add_known(40'h0, 1'b0, 3'd1, 32'd0, 32'd1);
        add_known(40'h0, 1'b1, 3'd1, 32'd1, 32'd1);
        add_known(40'hFF_FFFF_FFFF, 1'b0, 3'd0, 32'd1, 32'd2);
        add_known(40'hFF_FFFF_FFFF, 1'b1, 3'd0, 32'd2, 32'd2);
        // Same tag in two ways: one way in use fills way 0, then all ways see both copies
        add_write(CFG_WAYS_LOG2, 4'd0);
        add_known(40'h0, 1'b0, 3'd0, 32'd2, 32'd3);
        add_write(CFG_WAYS_LOG2, 4'd3);
        add_known(40'h0, 1'b1, 3'd0, 32'd3, 32'd3);
        // Byte lines and a single set (index write masked to 3 bits)
        add_write(CFG_OFFSET_BITS, 4'd0);
        add_write(CFG_INDEX_BITS, 4'd8);
        add_access(40'h1);
        add_access(40'h80_0000_0000);
        add_access(40'h1);
        // Oversized offset and index fall back to their clamps
        add_write(CFG_OFFSET_BITS, 4'd15);
        add_write(CFG_INDEX_BITS, 4'd7);
        add_access(40'hFFF);
        add_access(40'h1000);
        // Write to the unused index, then two ways (data masked to 2 bits)
        add_write(CFG_IDX_SPARE, 4'hF);
        add_write(CFG_WAYS_LOG2, 4'hD);
        add_access(40'h12_3456_789A);
        add_access(40'h12_3456_789A);

        foreach (plan[i]) begin
            row = plan[i];
            if (row.is_write) begin
                write_register(row.reg_idx, row.reg_data);
            end else begin
                push_address(row.addr, row.known, row.fixed);
            end
        end

        // Random phases: new split per phase, then a mix of reuse, same-set conflicts
        // and fresh addresses over a small working set so hits and evictions both occur.
        total = 0;
        while (total < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 3))
                0:       write_register(CFG_OFFSET_BITS, 4'd0);
                1:       write_register(CFG_OFFSET_BITS, 4'($urandom_range(12, 15)));
                default: write_register(CFG_OFFSET_BITS, 4'($urandom_range(0, 15)));
            endcase
            write_register(CFG_INDEX_BITS, 4'($urandom_range(0, 15)));
            write_register(CFG_WAYS_LOG2, 4'($urandom_range(0, 15)));
            if ($urandom_range(0, 3) == 0) write_register(CFG_IDX_SPARE,
                                                          4'($urandom_range(0, 15)));
            for (int p = 0; p < POOL_SIZE; p++) addr_pool[p] = random_address();
            n = $urandom_range(60, 200);
            if (n > RANDOM_ITEMS - total) n = RANDOM_ITEMS - total;
            repeat (n) begin
                k = $urandom_range(0, POOL_SIZE - 1);
                addr = addr_pool[k];
                case ($urandom_range(0, 3)) inside
                    0, 1: begin
                        // same address, maybe with its low six bits changed
                        if ($urandom_range(0, 1) == 1) addr[5:0] = 6'($urandom);
                    end
                    2: begin
                        // flip a bit above any index: same set, other tag
                        b = $urandom_range(18, 39);
                        addr[b] = ~addr[b];
                    end
                    default: begin
                        addr = random_address();
                        if ($urandom_range(0, 3) == 0) addr_pool[k] = addr;
                    end
                endcase
                push_address(addr, 1'b0, '0);
                total++;
            end
        end

        i_s_tvalid <= 1'b0;
        while (expected_lookups.size() != 0) @(posedge i_clk);
        // let any stray beat show up before the verdict
        repeat (LATENCY + 8) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
